@@ design/fvn_pkg.sv @@
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared types, constants and helpers for the fractal value noise pipeline.
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int OCT_W   = 4;    // octave index, up to sixteen octaves
    localparam int VAL_W   = 18;   // lattice / noise value, signed Q1.16
    localparam int AMP_W   = 17;   // amplitude, unsigned Q1.16 up to 1.0
    localparam int SUM_W   = 48;   // sample point kept modulo 2^48 (Q32.16)
    localparam int LANES   = 16;   // 4x4 lattice neighborhood

    localparam logic [AMP_W-1:0] AMP_ONE      = 17'd65536;
    localparam logic [31:0]      HASH_ROW     = 32'd57;
    localparam int               HASH_SHL     = 13;
    localparam logic [31:0]      HASH_MUL     = 32'd15731;
    localparam logic [31:0]      HASH_ADD_A   = 32'd789221;
    localparam logic [31:0]      HASH_ADD_B   = 32'd1376312589;

    localparam logic [1:0] REG_PERSISTENCE = 2'd0;
    localparam logic [1:0] REG_BASE_FREQ   = 2'd1;
    localparam logic [1:0] REG_OCT_OFFSET  = 2'd2;

    localparam logic [16:0] PERS_RESET = 17'd42860;
    localparam logic [23:0] FREQ_RESET = 24'd3293;
    localparam logic [31:0] OFFS_RESET = 32'd0;

    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic [OCT_W-1:0]    oct;
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic [SUM_W-1:0]    shift;
        logic [AMP_W-1:0]    amp;
    } issue_t;

    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic [15:0]         fx;
        logic [15:0]         fy;
        logic [AMP_W-1:0]    amp;
    } side_t;

    function automatic logic [31:0] mul32lo(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    // offset of lane k from the hash base: dx + 57*dy, dx,dy in -1..2
    function automatic logic [31:0] lane_off(input int k);
        int dx;
        int dy;
        dx = (k % 4) - 1;
        dy = (k / 4) - 1;
        return 32'(dx + 57 * dy);
    endfunction

endpackage

@@ design/fvn_seq.sv @@
// ----------------------------------------------------------------------------
// fvn_seq
// Octave sequencer: issues one octave of a point per cycle with its offset
// and amplitude.
// ----------------------------------------------------------------------------
module fvn_seq #(
    parameter int OCTAVES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [31:0]    coord_x,
    input  logic signed [31:0]    coord_y,
    input  logic [16:0]           pers,
    input  logic [31:0]           offs,
    output logic                  busy,
    output fvn_pkg::issue_t       issue
);

    localparam int IW = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
    localparam logic [IW-1:0] LAST_OCT = IW'(OCTAVES - 1);

    logic                         active_reg, active_next;
    logic [IW-1:0]                cnt_reg, cnt_next;
    logic signed [31:0]           x_reg, x_next;
    logic signed [31:0]           y_reg, y_next;
    logic [fvn_pkg::SUM_W-1:0]    shift_reg, shift_next;
    logic [fvn_pkg::AMP_W-1:0]    amp_reg, amp_next;
    logic [fvn_pkg::AMP_W-1:0]    pers_c;
    logic [fvn_pkg::SUM_W-1:0]    offs_x;
    logic [2*fvn_pkg::AMP_W-1:0]  amp_prod;
    logic                         take;
    logic                         is_last;

    assign pers_c   = (pers > fvn_pkg::AMP_ONE) ? fvn_pkg::AMP_ONE : pers;
    assign offs_x   = {{(fvn_pkg::SUM_W-32){offs[31]}}, offs};
    assign amp_prod = amp_reg * pers_c;
    assign take     = start && !active_reg;
    assign is_last  = (cnt_reg == LAST_OCT);
    assign busy     = active_reg;

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        shift_next  = shift_reg;
        amp_next    = amp_reg;
        issue       = '0;
        if (take)
        begin
            issue.valid = 1'b1;
            issue.first = 1'b1;
            issue.last  = (OCTAVES == 1);
            issue.oct   = '0;
            issue.x     = coord_x;
            issue.y     = coord_y;
            issue.shift = '0;
            issue.amp   = fvn_pkg::AMP_ONE;
            active_next = (OCTAVES > 1);
            cnt_next    = IW'(1);
            x_next      = coord_x;
            y_next      = coord_y;
            shift_next  = offs_x;
            amp_next    = pers_c;
        end
        else if (active_reg)
        begin
            issue.valid = 1'b1;
            issue.first = 1'b0;
            issue.last  = is_last;
            issue.oct   = fvn_pkg::OCT_W'(cnt_reg);
            issue.x     = x_reg;
            issue.y     = y_reg;
            issue.shift = shift_reg;
            issue.amp   = amp_reg;
            active_next = !is_last;
            cnt_next    = cnt_reg + IW'(1);
            shift_next  = shift_reg + offs_x;
            amp_next    = amp_prod[16 +: fvn_pkg::AMP_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        shift_reg <= shift_next;
        amp_reg   <= amp_next;
    end

endmodule

@@ design/fvn_hash.sv @@
// ----------------------------------------------------------------------------
// fvn_hash
// Four-stage lattice hash pipeline over the 4x4 cells around one sample.
// ----------------------------------------------------------------------------
module fvn_hash (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  fvn_pkg::side_t                            side_in,
    input  logic [31:0]                               ix,
    input  logic [31:0]                               iy,
    output fvn_pkg::side_t                            side_out,
    output logic signed [fvn_pkg::VAL_W-1:0]          vals [fvn_pkg::LANES]
);

    localparam int L = fvn_pkg::LANES;

    fvn_pkg::side_t      side_reg [4];
    logic [31:0]         n1_reg [L];
    logic [31:0]         n2_reg [L];
    logic [31:0]         n3_reg [L];
    logic [31:0]         sq_reg [L];
    logic [31:0]         t_reg  [L];
    logic signed [fvn_pkg::VAL_W-1:0] val_reg [L];
    logic [31:0]         base;

    assign base = ix + fvn_pkg::mul32lo(iy, fvn_pkg::HASH_ROW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 4; s++)
            begin
                side_reg[s] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s < 4; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < L; k++)
        begin
            logic [31:0] nb;
            logic [31:0] m;
            nb = base + fvn_pkg::lane_off(k);
            n1_reg[k] <= (nb << fvn_pkg::HASH_SHL) ^ nb;
            n2_reg[k] <= n1_reg[k];
            sq_reg[k] <= fvn_pkg::mul32lo(n1_reg[k], n1_reg[k]);
            n3_reg[k] <= n2_reg[k];
            t_reg[k]  <= fvn_pkg::mul32lo(sq_reg[k], fvn_pkg::HASH_MUL)
                         + fvn_pkg::HASH_ADD_A;
            m = fvn_pkg::mul32lo(n3_reg[k], t_reg[k]) + fvn_pkg::HASH_ADD_B;
            val_reg[k] <= $signed(18'd65536) - $signed({1'b0, m[30:14]});
        end
    end

    assign side_out = side_reg[3];
    assign vals     = val_reg;

endmodule

@@ design/fvn_interp.sv @@
// ----------------------------------------------------------------------------
// fvn_interp
// 3x3 smoothing of four corners, then bilinear blend in x and in y.
// ----------------------------------------------------------------------------
module fvn_interp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fvn_pkg::side_t                       side_in,
    input  logic signed [fvn_pkg::VAL_W-1:0]     vals [fvn_pkg::LANES],
    output fvn_pkg::side_t                       side_out,
    output logic signed [fvn_pkg::VAL_W-1:0]     noise
);

    localparam int VW = fvn_pkg::VAL_W;

    fvn_pkg::side_t       side_reg [3];
    logic signed [VW-1:0] sm_reg [4];
    logic signed [VW-1:0] i1_reg, i2_reg;
    logic signed [VW-1:0] out_reg;
    logic [15:0]          fy_hold_reg;

    function automatic logic signed [VW-1:0] smooth(
        input logic signed [VW-1:0] v [fvn_pkg::LANES], input int cx, input int cy);
        logic signed [VW+3:0] acc;
        acc = '0;
        for (int dy = 0; dy < 3; dy++)
        begin
            for (int dx = 0; dx < 3; dx++)
            begin
                logic signed [VW+3:0] e;
                e = (VW+4)'(v[(cy + dy) * 4 + cx + dx]);
                if (dx == 1 && dy == 1)
                begin
                    acc = acc + (e <<< 2);
                end
                else if (dx == 1 || dy == 1)
                begin
                    acc = acc + (e <<< 1);
                end
                else
                begin
                    acc = acc + e;
                end
            end
        end
        return acc[VW+3:4];
    endfunction

    function automatic logic signed [VW-1:0] blend(
        input logic signed [VW-1:0] a, input logic signed [VW-1:0] b, input logic [15:0] t);
        logic signed [VW:0]    d;
        logic signed [VW+17:0] p;
        logic signed [VW+1:0]  r;
        d = (VW+1)'(b) - (VW+1)'(a);
        p = d * $signed({1'b0, t});
        r = (VW+2)'(a) + p[VW+17:16];
        return r[VW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 3; s++)
            begin
                side_reg[s] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= side_in;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        sm_reg[0] <= smooth(vals, 0, 0);
        sm_reg[1] <= smooth(vals, 1, 0);
        sm_reg[2] <= smooth(vals, 0, 1);
        sm_reg[3] <= smooth(vals, 1, 1);
        i1_reg    <= blend(sm_reg[0], sm_reg[1], side_reg[0].fx);
        i2_reg    <= blend(sm_reg[2], sm_reg[3], side_reg[0].fx);
        fy_hold_reg <= side_reg[0].fy;
        out_reg   <= blend(i1_reg, i2_reg, fy_hold_reg);
    end

    assign side_out = side_reg[2];
    assign noise    = out_reg;

endmodule

@@ design/fractal_value_noise_2d.sv @@
// ----------------------------------------------------------------------------
// fractal_value_noise_2d
// Fixed-point 2D fractal value noise, one octave per cycle in a deep pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with coord_x/coord_y (Q16.16) while busy is low; the point is
//   taken at that edge. The block then issues one octave per cycle, so busy
//   stays high until the last octave has been issued, and a new point may be
//   started in the very next cycle busy is low; each point holds the single
//   octave datapath for all OCTAVES octaves (8 by default).
//   result_valid pulses for one cycle with noise_value (Q5.16, saturated);
//   it rises once the last octave of the point has passed the stages: sample
//   point (2), lattice hash (4), smoothing and two blends (3), amplitude
//   weight (1), accumulate (1). Results cannot be held off; each appears
//   exactly once.
//   Config: cfg_valid/cfg_ready with cfg_index (0 persistence, 1 base
//   frequency, 2 octave offset) and cfg_data; other indexes are ignored.
//   cfg_ready is always high; write only while no point is in flight.
//   Reset (rst_n low, async) restores the register defaults and drops all
//   beats in flight.
// ----------------------------------------------------------------------------
module fractal_value_noise_2d #(
    parameter int OCTAVES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    output logic                result_valid,
    output logic signed [21:0]  noise_value,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int VW = fvn_pkg::VAL_W;
    localparam int AW = fvn_pkg::AMP_W;
    localparam int TW = 40;

    logic [16:0]             pers_reg;
    logic [23:0]             freq_reg;
    logic [31:0]             offs_reg;
    fvn_pkg::issue_t         issue;
    fvn_pkg::issue_t         s1_reg;
    logic signed [56:0]      px_reg, py_reg;
    fvn_pkg::side_t          s2_reg;
    logic [31:0]             ix_reg, iy_reg;
    fvn_pkg::side_t          h_side;
    logic signed [VW-1:0]    h_vals [fvn_pkg::LANES];
    fvn_pkg::side_t          n_side;
    logic signed [VW-1:0]    n_val;
    logic                    w_valid_reg, w_first_reg, w_last_reg;
    logic signed [VW+AW-1:0] w_reg;
    logic signed [TW-1:0]    acc_reg, acc_next;
    logic                    res_valid_reg;
    logic signed [21:0]      res_reg;
    logic signed [TW-17:0]   res_full;
    logic [71:0]             ex_x, ex_y;
    logic [fvn_pkg::SUM_W-1:0] sx, sy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pers_reg <= fvn_pkg::PERS_RESET;
            freq_reg <= fvn_pkg::FREQ_RESET;
            offs_reg <= fvn_pkg::OFFS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fvn_pkg::REG_PERSISTENCE: pers_reg <= cfg_data[16:0];
                fvn_pkg::REG_BASE_FREQ:   freq_reg <= cfg_data[23:0];
                fvn_pkg::REG_OCT_OFFSET:  offs_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    fvn_seq #(.OCTAVES(OCTAVES)) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .coord_x (coord_x),
        .coord_y (coord_y),
        .pers    (pers_reg),
        .offs    (offs_reg),
        .busy    (busy),
        .issue   (issue)
    );

    // stage 1: coordinate times base frequency, exact Q.32
    // stage 2: scale by 2^octave, floor to Q.16, add octave offset
    assign ex_x = {{15{px_reg[56]}}, px_reg} << s1_reg.oct;
    assign ex_y = {{15{py_reg[56]}}, py_reg} << s1_reg.oct;
    assign sx   = ex_x[63:16] + s1_reg.shift;
    assign sy   = ex_y[63:16] + s1_reg.shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            w_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= issue;
            s2_reg.valid  <= s1_reg.valid;
            s2_reg.first  <= s1_reg.first;
            s2_reg.last   <= s1_reg.last;
            s2_reg.amp    <= s1_reg.amp;
            s2_reg.fx     <= sx[15:0];
            s2_reg.fy     <= sy[15:0];
            w_valid_reg   <= n_side.valid;
            res_valid_reg <= w_valid_reg && w_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= issue.x * $signed({1'b0, freq_reg});
        py_reg       <= issue.y * $signed({1'b0, freq_reg});
        ix_reg       <= sx[47:16];
        iy_reg       <= sy[47:16];
        w_first_reg  <= n_side.first;
        w_last_reg   <= n_side.last;
        w_reg        <= n_val * $signed({1'b0, n_side.amp});
        if (w_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        res_reg      <= (res_full > 24'sd1048576)  ? 22'sd1048576 :
                        (res_full < -24'sd1048576) ? -22'sd1048576 : res_full[21:0];
    end

    assign acc_next = (w_first_reg ? '0 : acc_reg) + TW'(w_reg);
    assign res_full = acc_next[TW-1:16];

    fvn_hash u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (s2_reg),
        .ix       (ix_reg),
        .iy       (iy_reg),
        .side_out (h_side),
        .vals     (h_vals)
    );

    fvn_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (h_side),
        .vals     (h_vals),
        .side_out (n_side),
        .noise    (n_val)
    );

    assign result_valid = res_valid_reg;
    assign noise_value  = res_reg;

endmodule

@@ design/fvn_checker.sv @@
// ----------------------------------------------------------------------------
// fvn_checker
// Port-level checks for fractal_value_noise_2d.
// ----------------------------------------------------------------------------
module fvn_checker #(
    parameter int OCTAVES = 8
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                result_valid,
    input logic signed [21:0]  noise_value
);

    // saturation bound on every result beat
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (noise_value <= 22'sd1048576 && noise_value >= -22'sd1048576))
        else $error("noise_value out of range");

    // with more than one octave, points never start back to back, so results do not either
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (OCTAVES > 1 && result_valid) |=> !result_valid)
        else $error("back-to-back result beats");

    // a taken point holds the issue slot for the remaining octaves
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (OCTAVES > 1 && start && !busy) |=> busy)
        else $error("busy not raised after start");

endmodule

bind fractal_value_noise_2d fvn_checker #(.OCTAVES(OCTAVES)) u_fvn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .noise_value  (noise_value)
);
